/* hw/rtl/satc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package satc_pkg;

   localparam int PORT_WIDTH         = 32;
   localparam int COORD_WIDTH_DEF    = 32;
   localparam int AXIS_FRAC_BITS_DEF = 16;
   localparam int NUM_VERTICES       = 8;
   localparam int VIDX_W             = 3;
   localparam int NUM_AXES           = 4;
   localparam int AXIS_W             = 2;
   localparam int NORM_LIMIT_BIT     = 30;
   localparam int SQRT_STEPS         = 31;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SIDE_A,
      ST_SIDE_B,
      ST_NORM,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQRT,
      ST_DIV_SET,
      ST_DIV_X,
      ST_DIV_Y,
      ST_PROJ_X,
      ST_PROJ_Y,
      ST_PROJ_MM,
      ST_OVL,
      ST_MTV_X,
      ST_MTV_Y,
      ST_MTV_S,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

/* hw/rtl/satc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface satc_req_if;
   import satc_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [PORT_WIDTH-1:0] vertex_x;
   logic signed [PORT_WIDTH-1:0] vertex_y;
   logic                         start_pair;
   modport source (output valid, vertex_x, vertex_y, start_pair, input ready);
   modport sink (input valid, vertex_x, vertex_y, start_pair, output ready);
endinterface

interface satc_rsp_if;
   import satc_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         collide;
   logic signed [PORT_WIDTH-1:0] mtv_x;
   logic signed [PORT_WIDTH-1:0] mtv_y;
   logic                         degenerate;
   modport source (output valid, collide, mtv_x, mtv_y, degenerate, input ready);
   modport sink (input valid, collide, mtv_x, mtv_y, degenerate, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sat_rect_collision_mtv.sv */
// Rectangle pair collision with minimum translation vector. Send eight vertex
// transfers (four corners of A, then four of B, start_pair on the first); the
// eighth starts the test and the block then holds req ready low until the
// result is in the output register. The test runs on one shared multiplier,
// a bit-serial square root (31 steps) and a restoring divider
// (AXIS_FRAC_BITS+1 steps per component). Per side: edge vector, up to
// COORD_WIDTH-29 normalising shifts, squares, square root and divide of both
// components; then projection of the eight vertices on each of the four axes,
// the MTV, and the load of the output register. A result waits in the output
// register while new vertices are taken.
`timescale 1ns / 1ps
`default_nettype none
module sat_rect_collision_mtv #(
   parameter int COORD_WIDTH    = satc_pkg::COORD_WIDTH_DEF,
   parameter int AXIS_FRAC_BITS = satc_pkg::AXIS_FRAC_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   satc_req_if.sink    req_chan,
   satc_rsp_if.source  rsp_chan
);
   import satc_pkg::*;

   localparam int CW      = COORD_WIDTH;
   localparam int F       = AXIS_FRAC_BITS;
   localparam int MW      = CW + 1;
   localparam int OVW     = CW + 3;
   localparam int MA      = (OVW > 31) ? OVW : 31;
   localparam int AW      = F + 2;
   localparam int MB      = (AW > 31) ? AW : 31;
   localparam int PW      = MA + MB;
   localparam int SQW     = 2 * NORM_LIMIT_BIT + 2;
   localparam int LW      = NORM_LIMIT_BIT + 1;
   localparam int DW      = F + LW;
   localparam int QW      = F + 1;
   localparam int RW      = (CW < PORT_WIDTH) ? CW : PORT_WIDTH;
   localparam int DIV_STEPS = F + 1;
   localparam int STEP_MAX  = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
   localparam int STW       = $clog2(STEP_MAX);
   localparam logic [SQW-1:0] SQRT_BIT0 = {2'b01, {(SQW-2){1'b0}}};
   localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< (RW - 1)) - PW'(1);
   localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

   function automatic logic signed [RW-1:0] sat_rw(input logic signed [PW-1:0] v);
      logic signed [RW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[RW-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[RW-1:0];
      end else begin
         r = v[RW-1:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [VIDX_W-1:0]    cnt_ff, cnt_in;
   logic [2*CW-1:0]      store_ff [NUM_VERTICES];
   logic [AXIS_W-1:0]    side_ff, side_in;
   logic [VIDX_W-1:0]    vidx_ff, vidx_in;
   logic [STW-1:0]       step_ff, step_in;
   logic signed [CW-1:0] c0x_ff, c0x_in, c0y_ff, c0y_in;
   logic                 dx_neg_ff, dx_neg_in, dy_neg_ff, dy_neg_in;
   logic [MW-1:0]        mx_ff, mx_in, my_ff, my_in;
   logic [SQW-1:0]       sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [DW-1:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic signed [AW-1:0] ax_ff [NUM_AXES];
   logic signed [AW-1:0] ay_ff [NUM_AXES];
   logic                 ax_we, ay_we;
   logic signed [AW-1:0] axis_val;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [OVW-1:0] amin_ff, amin_in, amax_ff, amax_in;
   logic signed [OVW-1:0] bmin_ff, bmin_in, bmax_ff, bmax_in;
   logic signed [OVW-1:0] best_ff, best_in;
   logic signed [AW-1:0]  bax_ff, bax_in, bay_ff, bay_in;
   logic signed [OVW-1:0] bamin_ff, bamin_in, bamax_ff, bamax_in;
   logic signed [OVW-1:0] bbmin_ff, bbmin_in, bbmax_ff, bbmax_in;
   logic signed [RW-1:0]  mtvx_ff, mtvx_in;
   logic                  res_col_ff, res_col_in, res_deg_ff, res_deg_in;
   logic signed [PORT_WIDTH-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_col_ff, rsp_deg_ff;
   logic signed [PORT_WIDTH-1:0] rsp_x_ff, rsp_y_ff;

   logic                  req_xfer, rsp_free, rsp_load;
   logic [VIDX_W-1:0]     widx;
   logic [63:0]           ext_x, ext_y;
   logic [VIDX_W-1:0]     rd_idx;
   logic signed [CW-1:0]  rd_x, rd_y;
   logic signed [MW-1:0]  dx, dy;
   logic                  side_zero;
   logic [63:0]           mx64, my64, mor64;
   logic                  norm_big;
   logic signed [MA-1:0]  mul_a;
   logic signed [MB-1:0]  mul_b;
   logic signed [PW-1:0]  prod, acc_sh;
   logic signed [OVW-1:0] proj, ov_hi, ov_lo, ov, sg_hi, sg_lo;
   logic                  sq_ge, div_ge, div_last, sqrt_last, flip;
   logic [SQW-1:0]        sq_t;
   logic [QW-1:0]         quo_fin;
   logic signed [AW-1:0]  q_s;
   logic signed [RW-1:0]  mtvy, rx, ry;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load = (state_ff == ST_FINISH) && rsp_free;
   assign widx = req_chan.start_pair ? '0 : cnt_ff;
   assign ext_x = 64'($unsigned(req_chan.vertex_x));
   assign ext_y = 64'($unsigned(req_chan.vertex_y));

   always_comb begin
      case (state_ff)
         ST_SIDE_A: rd_idx = {side_ff[1], 2'b00};
         ST_SIDE_B: rd_idx = {side_ff[1], side_ff[0], 1'b1};
         default:   rd_idx = vidx_ff;
      endcase
   end
   assign rd_x = $signed(store_ff[rd_idx][2*CW-1:CW]);
   assign rd_y = $signed(store_ff[rd_idx][CW-1:0]);

   assign dx = MW'(c0x_ff) - MW'(rd_x);
   assign dy = MW'(c0y_ff) - MW'(rd_y);
   assign side_zero = (dx == '0) && (dy == '0);
   assign mx64 = 64'(mx_ff);
   assign my64 = 64'(my_ff);
   assign mor64 = mx64 | my64;
   assign norm_big = |mor64[63:NORM_LIMIT_BIT];

   always_comb begin
      case (state_ff)
         ST_SQ_X: begin
            mul_a = MA'($signed({1'b0, mx64[NORM_LIMIT_BIT-1:0]}));
            mul_b = MB'($signed({1'b0, mx64[NORM_LIMIT_BIT-1:0]}));
         end
         ST_SQ_Y: begin
            mul_a = MA'($signed({1'b0, my64[NORM_LIMIT_BIT-1:0]}));
            mul_b = MB'($signed({1'b0, my64[NORM_LIMIT_BIT-1:0]}));
         end
         ST_PROJ_X: begin
            mul_a = MA'(rd_x);
            mul_b = MB'(ax_ff[side_ff]);
         end
         ST_PROJ_Y: begin
            mul_a = MA'(rd_y);
            mul_b = MB'(ay_ff[side_ff]);
         end
         ST_MTV_X: begin
            mul_a = MA'(best_ff);
            mul_b = MB'(bax_ff);
         end
         default: begin
            mul_a = MA'(best_ff);
            mul_b = MB'(bay_ff);
         end
      endcase
   end
   assign prod = PW'(mul_a) * PW'(mul_b);
   assign acc_sh = acc_ff >>> F;
   assign proj = acc_sh[OVW-1:0];

   assign sq_t = sq_r_ff + sq_bit_ff;
   assign sq_ge = (sq_v_ff >= sq_t);
   assign sqrt_last = (step_ff == STW'(SQRT_STEPS - 1));
   assign div_ge = (rem_ff >= dvs_ff);
   assign div_last = (step_ff == STW'(DIV_STEPS - 1));
   assign quo_fin = {quo_ff[QW-2:0], div_ge};
   assign q_s = $signed({1'b0, quo_fin});

   assign ov_hi = (amax_ff < bmax_ff) ? amax_ff : bmax_ff;
   assign ov_lo = (amin_ff > bmin_ff) ? amin_ff : bmin_ff;
   assign ov = (ov_hi > ov_lo) ? (ov_hi - ov_lo) : '0;

   assign sg_hi = ((bamax_ff + best_ff) < bbmax_ff) ? (bamax_ff + best_ff) : bbmax_ff;
   assign sg_lo = ((bamin_ff + best_ff) > bbmin_ff) ? (bamin_ff + best_ff) : bbmin_ff;
   assign flip = (sg_hi > sg_lo);
   assign mtvy = sat_rw(acc_sh);
   assign rx = flip ? sat_rw(-PW'(mtvx_ff)) : mtvx_ff;
   assign ry = flip ? sat_rw(-PW'(mtvy)) : mtvy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (widx == VIDX_W'(NUM_VERTICES - 1))) begin
               state_in = ST_SIDE_A;
            end
         end
         ST_SIDE_A:  state_in = ST_SIDE_B;
         ST_SIDE_B:  state_in = side_zero ? ST_FINISH : ST_NORM;
         ST_NORM: begin
            if (!norm_big) begin
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X:    state_in = ST_SQ_Y;
         ST_SQ_Y:    state_in = ST_SQRT;
         ST_SQRT: begin
            if (sqrt_last) begin
               state_in = ST_DIV_SET;
            end
         end
         ST_DIV_SET: state_in = ST_DIV_X;
         ST_DIV_X: begin
            if (div_last) begin
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_last) begin
               state_in = (side_ff == AXIS_W'(NUM_AXES - 1)) ? ST_PROJ_X : ST_SIDE_A;
            end
         end
         ST_PROJ_X:  state_in = ST_PROJ_Y;
         ST_PROJ_Y:  state_in = ST_PROJ_MM;
         ST_PROJ_MM: begin
            state_in = (vidx_ff == VIDX_W'(NUM_VERTICES - 1)) ? ST_OVL : ST_PROJ_X;
         end
         ST_OVL: begin
            if (ov == '0) begin
               state_in = ST_FINISH;
            end else if (side_ff == AXIS_W'(NUM_AXES - 1)) begin
               state_in = ST_MTV_X;
            end else begin
               state_in = ST_PROJ_X;
            end
         end
         ST_MTV_X:   state_in = ST_MTV_Y;
         ST_MTV_Y:   state_in = ST_MTV_S;
         ST_MTV_S:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      side_in = side_ff;
      vidx_in = vidx_ff;
      step_in = step_ff;
      c0x_in = c0x_ff;
      c0y_in = c0y_ff;
      dx_neg_in = dx_neg_ff;
      dy_neg_in = dy_neg_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      sq_v_in = sq_v_ff;
      sq_r_in = sq_r_ff;
      sq_bit_in = sq_bit_ff;
      len_in = len_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      ax_we = 1'b0;
      ay_we = 1'b0;
      axis_val = dy_neg_ff ? q_s : -q_s;
      acc_in = acc_ff;
      amin_in = amin_ff;
      amax_in = amax_ff;
      bmin_in = bmin_ff;
      bmax_in = bmax_ff;
      best_in = best_ff;
      bax_in = bax_ff;
      bay_in = bay_ff;
      bamin_in = bamin_ff;
      bamax_in = bamax_ff;
      bbmin_in = bbmin_ff;
      bbmax_in = bbmax_ff;
      mtvx_in = mtvx_ff;
      res_col_in = res_col_ff;
      res_deg_in = res_deg_ff;
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cnt_in = widx + VIDX_W'(1);
               side_in = '0;
               vidx_in = '0;
            end
         end
         ST_SIDE_A: begin
            c0x_in = rd_x;
            c0y_in = rd_y;
         end
         ST_SIDE_B: begin
            dx_neg_in = dx[MW-1];
            dy_neg_in = dy[MW-1];
            mx_in = dx[MW-1] ? MW'(-dx) : MW'(dx);
            my_in = dy[MW-1] ? MW'(-dy) : MW'(dy);
            res_col_in = 1'b0;
            res_deg_in = 1'b1;
            res_x_in = '0;
            res_y_in = '0;
         end
         ST_NORM: begin
            if (norm_big) begin
               mx_in = mx_ff >> 1;
               my_in = my_ff >> 1;
            end
         end
         ST_SQ_X: sq_v_in = prod[SQW-1:0];
         ST_SQ_Y: begin
            sq_v_in = sq_v_ff + prod[SQW-1:0];
            sq_r_in = '0;
            sq_bit_in = SQRT_BIT0;
            step_in = '0;
         end
         ST_SQRT: begin
            sq_v_in = sq_ge ? (sq_v_ff - sq_t) : sq_v_ff;
            sq_r_in = sq_ge ? ((sq_r_ff >> 1) + sq_bit_ff) : (sq_r_ff >> 1);
            sq_bit_in = sq_bit_ff >> 2;
            step_in = step_ff + STW'(1);
            len_in = sq_r_in[LW-1:0];
         end
         ST_DIV_SET: begin
            rem_in = DW'({my64[NORM_LIMIT_BIT-1:0], {F{1'b0}}}) + DW'(len_ff >> 1);
            dvs_in = {len_ff, {F{1'b0}}};
            quo_in = '0;
            step_in = '0;
         end
         ST_DIV_X, ST_DIV_Y: begin
            rem_in = div_ge ? (rem_ff - dvs_ff) : rem_ff;
            dvs_in = dvs_ff >> 1;
            quo_in = quo_fin;
            step_in = step_ff + STW'(1);
            if (div_last) begin
               step_in = '0;
               if (state_ff == ST_DIV_X) begin
                  ax_we = 1'b1;
                  rem_in = DW'({mx64[NORM_LIMIT_BIT-1:0], {F{1'b0}}}) + DW'(len_ff >> 1);
                  dvs_in = {len_ff, {F{1'b0}}};
                  quo_in = '0;
               end else begin
                  ay_we = 1'b1;
                  axis_val = dx_neg_ff ? -q_s : q_s;
                  side_in = side_ff + AXIS_W'(1);
                  vidx_in = '0;
               end
            end
         end
         ST_PROJ_X: acc_in = prod;
         ST_PROJ_Y: acc_in = acc_ff + prod;
         ST_PROJ_MM: begin
            if (!vidx_ff[2]) begin
               if ((vidx_ff[1:0] == 2'b00) || (proj < amin_ff)) amin_in = proj;
               if ((vidx_ff[1:0] == 2'b00) || (proj > amax_ff)) amax_in = proj;
            end else begin
               if ((vidx_ff[1:0] == 2'b00) || (proj < bmin_ff)) bmin_in = proj;
               if ((vidx_ff[1:0] == 2'b00) || (proj > bmax_ff)) bmax_in = proj;
            end
            vidx_in = vidx_ff + VIDX_W'(1);
         end
         ST_OVL: begin
            res_col_in = 1'b0;
            res_deg_in = 1'b0;
            res_x_in = '0;
            res_y_in = '0;
            if ((side_ff == '0) || (ov < best_ff)) begin
               best_in = ov;
               bax_in = ax_ff[side_ff];
               bay_in = ay_ff[side_ff];
               bamin_in = amin_ff;
               bamax_in = amax_ff;
               bbmin_in = bmin_ff;
               bbmax_in = bmax_ff;
            end
            side_in = side_ff + AXIS_W'(1);
         end
         ST_MTV_X: acc_in = prod;
         ST_MTV_Y: begin
            mtvx_in = sat_rw(acc_sh);
            acc_in = prod;
         end
         ST_MTV_S: begin
            res_col_in = 1'b1;
            res_deg_in = 1'b0;
            res_x_in = PORT_WIDTH'(rx);
            res_y_in = PORT_WIDTH'(ry);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         store_ff[widx] <= {ext_x[CW-1:0], ext_y[CW-1:0]};
      end
      if (ax_we) begin
         ax_ff[side_ff] <= axis_val;
      end
      if (ay_we) begin
         ay_ff[side_ff] <= axis_val;
      end
      if (rsp_load) begin
         rsp_col_ff <= res_col_ff;
         rsp_deg_ff <= res_deg_ff;
         rsp_x_ff <= res_x_ff;
         rsp_y_ff <= res_y_ff;
      end
      side_ff <= side_in;
      vidx_ff <= vidx_in;
      step_ff <= step_in;
      c0x_ff <= c0x_in;
      c0y_ff <= c0y_in;
      dx_neg_ff <= dx_neg_in;
      dy_neg_ff <= dy_neg_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      sq_v_ff <= sq_v_in;
      sq_r_ff <= sq_r_in;
      sq_bit_ff <= sq_bit_in;
      len_ff <= len_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      acc_ff <= acc_in;
      amin_ff <= amin_in;
      amax_ff <= amax_in;
      bmin_ff <= bmin_in;
      bmax_ff <= bmax_in;
      best_ff <= best_in;
      bax_ff <= bax_in;
      bay_ff <= bay_in;
      bamin_ff <= bamin_in;
      bamax_ff <= bamax_in;
      bbmin_ff <= bbmin_in;
      bbmax_ff <= bbmax_in;
      mtvx_ff <= mtvx_in;
      res_col_ff <= res_col_in;
      res_deg_ff <= res_deg_in;
      res_x_ff <= res_x_in;
      res_y_ff <= res_y_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.collide = rsp_col_ff;
   assign rsp_chan.degenerate = rsp_deg_ff;
   assign rsp_chan.mtv_x = rsp_x_ff;
   assign rsp_chan.mtv_y = rsp_y_ff;

   a_eighth_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_chan.start_pair && (cnt_ff == VIDX_W'(NUM_VERTICES - 1))
      |=> state_ff == ST_SIDE_A)
      else $error("eighth vertex did not start the test");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_SET |-> len_ff != '0)
      else $error("zero side length reached the divider");

   a_no_collide_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_load && !res_col_ff |-> (res_x_ff == '0) && (res_y_ff == '0))
      else $error("non-zero translation without collision");

   a_degen_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(res_col_ff && res_deg_ff))
      else $error("collision reported on a degenerate pair");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result load lost");

endmodule
`default_nettype wire
